// ===== hdl/att_pkg.sv =====
`timescale 1ns / 1ps

package att_pkg;

  // Field widths
  localparam int unsigned SAMPLE_W    = 10;
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned THRESH_W    = 11;
  localparam int unsigned COUNT_W     = 8;
  localparam int unsigned HOLDOFF_W   = 16;
  localparam int unsigned AVG_W       = 10;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned CFG_IDX_W   = 2;

  // Largest sample value, used to size the running total
  localparam int unsigned SAMPLE_MAX  = (1 << SAMPLE_W) - 1;

  // Default window length
  localparam int unsigned WINDOW_LEN_DEF = 10;

  // Stream word widths, padded to whole bytes
  localparam int unsigned IN_DATA_W   = ((SAMPLE_W + TIME_W + 7) / 8) * 8;
  localparam int unsigned OUT_DATA_W  = ((1 + AVG_W + 7) / 8) * 8;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_TRIGGERS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF      = 2'd2;

  // Register reset values
  localparam logic [THRESH_W-1:0]  THRESHOLD_RST    = '0;
  localparam logic [COUNT_W-1:0]   MIN_TRIGGERS_RST = 8'd1;
  localparam logic [HOLDOFF_W-1:0] HOLDOFF_RST      = '0;

  // Configuration handed to the decision stage
  typedef struct packed {
    logic [THRESH_W-1:0]  threshold;
    logic [COUNT_W-1:0]   min_triggers;
    logic [HOLDOFF_W-1:0] holdoff_ms;
  } cfg_t;

endpackage

// ===== hdl/att_cell.sv =====
`timescale 1ns / 1ps

// One slot of the sample window: takes the word from its neighbour on shift
module att_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          shift_i,
  input  logic [att_pkg::SAMPLE_W-1:0]  data_i,
  output logic [att_pkg::SAMPLE_W-1:0]  data_o
);

  logic [att_pkg::SAMPLE_W-1:0] data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= '0;
    end else if (shift_i) begin
      data_q <= data_i;
    end
  end

  assign data_o = data_q;

endmodule

// ===== hdl/att_detect.sv =====
`timescale 1ns / 1ps

// Threshold compare, consecutive count, holdoff check and output register
module att_detect (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  logic                          valid_i,
  input  logic [att_pkg::AVG_W-1:0]     avg_i,
  input  logic [att_pkg::TIME_W-1:0]    now_i,
  input  att_pkg::cfg_t                 cfg_i,
  output logic                          fired_o,
  output logic [att_pkg::AVG_W-1:0]     avg_o
);

  logic [att_pkg::COUNT_W-1:0] count_q, count_d, count_inc;
  logic [att_pkg::TIME_W-1:0]  last_q, last_d, elapsed;
  logic                        above, fire;
  logic                        fired_q;
  logic [att_pkg::AVG_W-1:0]   avg_q;

  // Decision for the word in this stage
  always_comb begin
    above     = {1'b0, avg_i} > cfg_i.threshold;
    count_inc = (count_q == '1) ? count_q : count_q + 1'b1;
    elapsed   = now_i - last_q;
    fire      = above && (count_inc >= cfg_i.min_triggers) &&
                (elapsed > {{(att_pkg::TIME_W - att_pkg::HOLDOFF_W){1'b0}},
                            cfg_i.holdoff_ms});
    last_d    = fire ? now_i : last_q;
    if (fire || !above) begin
      count_d = '0;
    end else begin
      count_d = count_inc;
    end
  end

  // Trigger state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      last_q  <= '0;
    end else if (adv_i && valid_i) begin
      count_q <= count_d;
      last_q  <= last_d;
    end
  end

  // Output word register
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      fired_q <= fire;
      avg_q   <= avg_i;
    end
  end

  assign fired_o = fired_q;
  assign avg_o   = avg_q;

endmodule

// ===== hdl/averaged_threshold_trigger.sv =====
`timescale 1ns / 1ps
// An accepted word updates the window and total, then the product, then the output register.
// Throughput: one word per cycle; the window is a chain of cells shifted once per
// word and the running total is one add/subtract, so the pipe only stalls while a
// result word waits at the output.
// Reset (rst_ni low, asynchronous): window, total, count and last trigger time go
// to zero, threshold 0, min_triggers 1, holdoff 0; no word is held in flight.
module averaged_threshold_trigger #(
  parameter int unsigned WINDOW_LEN = att_pkg::WINDOW_LEN_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration write port
  input  logic                            cfg_we_i,
  input  logic [att_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [att_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // Input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [att_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // sample[9:0], now_ms[41:10]
  // Output stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [att_pkg::OUT_DATA_W-1:0]  m_axis_tdata   // fired[0], average[10:1]
);

  // Running total width and reciprocal for the divide by WINDOW_LEN
  localparam int unsigned TOTAL_W = $clog2(WINDOW_LEN * att_pkg::SAMPLE_MAX + 1);
  localparam int unsigned DIV_L   = $clog2(WINDOW_LEN);
  localparam int unsigned SHIFT   = TOTAL_W + DIV_L;
  localparam int unsigned RECIP_W = TOTAL_W + 1;
  localparam longint unsigned RECIP_VAL =
    ((64'd1 << SHIFT) + WINDOW_LEN - 1) / WINDOW_LEN;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_VAL[RECIP_W-1:0];
  localparam int unsigned PROD_W  = TOTAL_W + RECIP_W;

  logic adv, s_acc;
  logic v1_q, v2_q, out_valid_q;

  logic [att_pkg::SAMPLE_W-1:0] sample_in;
  logic [att_pkg::TIME_W-1:0]   now_in, now1_q, now2_q;

  logic [att_pkg::SAMPLE_W-1:0] chain [WINDOW_LEN+1];
  logic [TOTAL_W-1:0]           total_q, total_d;
  logic [PROD_W-1:0]            prod_q;
  logic [att_pkg::AVG_W-1:0]    avg2;

  att_pkg::cfg_t cfg_q;
  logic          fired;
  logic [att_pkg::AVG_W-1:0] avg_out;

  // Handshake: the whole pipe moves when the output register can take a word
  assign adv           = !out_valid_q || m_axis_tready;
  assign s_axis_tready = adv;
  assign s_acc         = s_axis_tvalid && adv;
  assign m_axis_tvalid = out_valid_q;

  assign sample_in = s_axis_tdata[att_pkg::SAMPLE_W-1:0];
  assign now_in    = s_axis_tdata[att_pkg::SAMPLE_W +: att_pkg::TIME_W];

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold    <= att_pkg::THRESHOLD_RST;
      cfg_q.min_triggers <= att_pkg::MIN_TRIGGERS_RST;
      cfg_q.holdoff_ms   <= att_pkg::HOLDOFF_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        att_pkg::REG_THRESHOLD:
          cfg_q.threshold <= cfg_data_i[att_pkg::THRESH_W-1:0];
        att_pkg::REG_MIN_TRIGGERS:
          cfg_q.min_triggers <= cfg_data_i[att_pkg::COUNT_W-1:0];
        att_pkg::REG_HOLDOFF:
          cfg_q.holdoff_ms <= cfg_data_i[att_pkg::HOLDOFF_W-1:0];
        default: ;
      endcase
    end
  end

  // Window: chain of cells, the oldest sample drops out of the far end
  assign chain[0] = sample_in;

  for (genvar g = 0; g < WINDOW_LEN; g++) begin : g_cell
    att_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (s_acc),
      .data_i  (chain[g]),
      .data_o  (chain[g+1])
    );
  end

  // Running total
  assign total_d = total_q - TOTAL_W'(chain[WINDOW_LEN]) + TOTAL_W'(sample_in);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
    end else if (s_acc) begin
      total_q <= total_d;
    end
  end

  // Valid pipe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v1_q        <= s_acc;
      v2_q        <= v1_q;
      out_valid_q <= v2_q;
    end
  end

  // Timestamp travels alongside; reciprocal multiply for the average
  always_ff @(posedge clk_i) begin
    if (adv) begin
      now1_q <= now_in;
      now2_q <= now1_q;
      prod_q <= PROD_W'(total_q) * PROD_W'(RECIP);
    end
  end

  assign avg2 = att_pkg::AVG_W'(prod_q >> SHIFT);

  att_detect u_detect (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (v2_q),
    .avg_i   (avg2),
    .now_i   (now2_q),
    .cfg_i   (cfg_q),
    .fired_o (fired),
    .avg_o   (avg_out)
  );

  assign m_axis_tdata = {{(att_pkg::OUT_DATA_W - att_pkg::AVG_W - 1){1'b0}}, avg_out, fired};

endmodule

// ===== dv/averaged_threshold_trigger_tb.sv =====
`timescale 1ns / 1ps

module averaged_threshold_trigger_tb;

  localparam int unsigned WINDOW = att_pkg::WINDOW_LEN_DEF;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam logic [att_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // Fields of one result word (the block packs fired below the average)
  typedef struct packed {
    logic                      fired;
    logic [att_pkg::AVG_W-1:0] average;
  } trig_result_t;

  typedef enum int {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_e;

  // Trigger predictor and store of expected result words
  class trigger_scoreboard;
    logic [att_pkg::SAMPLE_W-1:0] ring [WINDOW];
    logic [13:0]                  total;
    int unsigned                  slot;
    logic [att_pkg::COUNT_W-1:0]  run_len;
    logic [att_pkg::TIME_W-1:0]   last_fire;
    att_pkg::cfg_t                cfg;
    trig_result_t                 expected_q [$];
    int unsigned                  errors;
    int unsigned                  checked;
    int unsigned                  fires;

    function new();
      foreach (ring[i]) ring[i] = '0;
      total     = '0;
      slot      = 0;
      run_len   = '0;
      last_fire = '0;
      cfg.threshold    = att_pkg::THRESHOLD_RST;
      cfg.min_triggers = att_pkg::MIN_TRIGGERS_RST;
      cfg.holdoff_ms   = att_pkg::HOLDOFF_RST;
      errors  = 0;
      checked = 0;
      fires   = 0;
    endfunction

    function void write_reg(logic [att_pkg::CFG_IDX_W-1:0] idx,
                            logic [att_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        att_pkg::REG_THRESHOLD:    cfg.threshold    = data[att_pkg::THRESH_W-1:0];
        att_pkg::REG_MIN_TRIGGERS: cfg.min_triggers = data[att_pkg::COUNT_W-1:0];
        att_pkg::REG_HOLDOFF:      cfg.holdoff_ms   = data[att_pkg::HOLDOFF_W-1:0];
        default: ;
      endcase
    endfunction

    // Take one accepted sample word into the window and predict its result
    function void note_input(logic [att_pkg::SAMPLE_W-1:0] smp,
                             logic [att_pkg::TIME_W-1:0] now);
      trig_result_t               res;
      logic [att_pkg::TIME_W-1:0] elapsed;
      total      = total - 14'(ring[slot]) + 14'(smp);
      ring[slot] = smp;
      slot       = (slot == WINDOW - 1) ? 0 : slot + 1;
      res.average = att_pkg::AVG_W'(total / WINDOW);
      res.fired   = 1'b0;
      if (11'(res.average) > cfg.threshold) begin
        if (run_len != 8'hFF) run_len++;
        elapsed = now - last_fire;  // modular, so wrap is handled
        if (run_len >= cfg.min_triggers && elapsed > 32'(cfg.holdoff_ms)) begin
          res.fired = 1'b1;
          run_len   = '0;
          last_fire = now;
          fires++;
        end
      end else begin
        run_len = '0;
      end
      expected_q.push_back(res);
    endfunction

    task report(string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic fired, logic [att_pkg::AVG_W-1:0] average);
      trig_result_t res;
      if (expected_q.size() == 0) begin
        report($sformatf("result word fired=%0d average=%0d with nothing expected",
                         fired, average));
      end else begin
        res = expected_q.pop_front();
        checked++;
        if (fired !== res.fired)
          report($sformatf("word %0d: fired %0d, expected %0d", checked, fired, res.fired));
        if (average !== res.average)
          report($sformatf("word %0d: average %0d, expected %0d",
                           checked, average, res.average));
      end
    endtask
  endclass

  logic                            clk_i;
  logic                            rst_ni        = 1'b0;
  logic                            cfg_we_i      = 1'b0;
  logic [att_pkg::CFG_IDX_W-1:0]   cfg_idx_i     = '0;
  logic [att_pkg::CFG_DATA_W-1:0]  cfg_data_i    = '0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [att_pkg::IN_DATA_W-1:0]   s_axis_tdata  = '0;  // sample[9:0], now_ms[41:10]
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [att_pkg::OUT_DATA_W-1:0]  m_axis_tdata;        // fired[0], average[10:1]

  trigger_scoreboard sb;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned cycle_cnt      = 0;
  int unsigned words_sent     = 0;
  int unsigned settings_cnt   = 0;

  // Burst state of the sample generator
  int unsigned burst_left = 0;
  bit          burst_high = 1'b0;
  logic [att_pkg::TIME_W-1:0] now_ms = '0;

  averaged_threshold_trigger u_top (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Result side: check each accepted word, then choose next ready
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata[0], m_axis_tdata[att_pkg::AVG_W:1]);
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("averaged_threshold_trigger verification failed");
      $finish;
    end
  end

  task automatic set_idling(idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SEND: begin send_idle_pct = 71; recv_stall_pct = 0;  end
      IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 71; end
      default:   begin send_idle_pct = 7;  recv_stall_pct = 7;  end
    endcase
  endtask

  // Offer one sample word and hold it until taken
  task automatic send_word(logic [att_pkg::SAMPLE_W-1:0] smp,
                           logic [att_pkg::TIME_W-1:0] now);
    int unsigned gap;
    gap = 0;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct && gap < 40) gap++;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(att_pkg::IN_DATA_W - att_pkg::SAMPLE_W - att_pkg::TIME_W){1'b0}},
                      now, smp};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_input(smp, now);
    words_sent++;
  endtask

  // Let every expected word drain before touching the registers
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [att_pkg::CFG_IDX_W-1:0] idx,
                           logic [att_pkg::CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    sb.write_reg(idx, data);
  endtask

  task automatic set_config(logic [att_pkg::CFG_DATA_W-1:0] thr,
                            logic [att_pkg::CFG_DATA_W-1:0] min_cnt,
                            logic [att_pkg::CFG_DATA_W-1:0] hold);
    wait_idle();
    write_reg(att_pkg::REG_THRESHOLD, thr);
    write_reg(att_pkg::REG_MIN_TRIGGERS, min_cnt);
    write_reg(att_pkg::REG_HOLDOFF, hold);
    settings_cnt++;
  endtask

  // Bursts of samples above and below the threshold, with some noise
  function automatic logic [att_pkg::SAMPLE_W-1:0] pick_sample();
    int unsigned lvl;
    lvl = (sb.cfg.threshold > att_pkg::SAMPLE_MAX) ? att_pkg::SAMPLE_MAX :
          32'(sb.cfg.threshold);
    if (burst_left == 0) begin
      burst_high = 1'($urandom_range(1));
      burst_left = $urandom_range(1, 15);
    end
    burst_left--;
    if ($urandom_range(9) == 0)
      return att_pkg::SAMPLE_W'($urandom_range(att_pkg::SAMPLE_MAX));
    if (burst_high) return att_pkg::SAMPLE_W'($urandom_range(lvl, att_pkg::SAMPLE_MAX));
    return att_pkg::SAMPLE_W'($urandom_range(0, lvl));
  endfunction

  task automatic run_phase(int unsigned step_max, int unsigned n_words, idle_mode_e mode);
    set_idling(mode);
    repeat (n_words) begin
      if ($urandom_range(29) == 0) now_ms = $urandom;
      else now_ms = now_ms + att_pkg::TIME_W'($urandom_range(step_max));
      send_word(pick_sample(), now_ms);
    end
  endtask

  initial begin
    sb = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset settings, field extremes and timestamp wrap
    send_word(10'd0, 32'd0);
    send_word(10'd1023, 32'd0);            // over threshold, no time elapsed
    send_word(10'd1023, 32'd1);            // fires
    send_word(10'd1023, 32'hFFFF_FFFF);    // fires after a long gap
    send_word(10'd1023, 32'd0);            // wrapped timestamp, elapsed is one
    send_word(10'd0, 32'd5);

    // Holdoff blocking with a zero minimum count
    set_config(16'd0, 16'd0, 16'd5);
    send_word(10'd1023, 32'd5);            // same time as the last firing, blocked by holdoff
    send_word(10'd1023, 32'd6);            // still within holdoff
    send_word(10'd1023, 32'd7);

    // Threshold at the average ceiling never fires; unused index ignored
    set_config(16'd1023, 16'd1, 16'd0);
    write_reg(REG_UNUSED, 16'hFFFF);
    send_word(10'd1023, 32'd100);
    send_word(10'd1023, 32'd200);
    set_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_word(10'd1023, 32'hFFFF_0000);
    set_config(16'd101, 16'd2, 16'd0);
    send_word(10'd1023, 32'd300);
    send_word(10'd1023, 32'd301);
    send_word(10'd0, 32'd302);
    send_word(10'd0, 32'd303);

    // Random phases over a range of settings and idling patterns
    set_config(16'd500, 16'd3, 16'd20);
    run_phase(10, 40, IDLE_NONE);
    set_config(16'd0, 16'd1, 16'd0);
    run_phase(3, 30, IDLE_SEND);
    set_config(16'd1023, 16'd1, 16'd0);
    run_phase(5, 20, IDLE_RECV);
    set_config(16'd200, 16'd0, 16'd65535);
    run_phase(40000, 30, IDLE_BOTH);
    set_config(16'd300, 16'd2, 16'd100);
    now_ms = 32'hFFFF_FF00;
    run_phase(50, 30, IDLE_NONE);
    set_config(16'($urandom), 16'($urandom_range(0, 6)), 16'($urandom_range(0, 500)));
    write_reg(REG_UNUSED, 16'($urandom));
    run_phase(1000, 30, IDLE_SEND);

    // Count saturation: hold time still so the holdoff blocks firing
    set_config(16'hF864, 16'hFFFF, 16'hFFFF);
    set_idling(IDLE_BOTH);
    repeat (260) send_word(10'd1023, sb.last_fire);
    send_word(10'd1023, sb.last_fire + 32'd65536);
    send_word(10'd1023, sb.last_fire + 32'd65536);

    set_config(16'($urandom), 16'($urandom), 16'($urandom));
    run_phase(100000, 20, IDLE_RECV);
    set_config(16'($urandom_range(0, 400)), 16'($urandom_range(0, 4)),
               16'($urandom_range(0, 30)));
    run_phase(20, 20, IDLE_BOTH);

    wait_idle();
    repeat (10) @(posedge clk_i);
    $display("Sent %0d sample words under %0d register settings, %0d idling patterns.",
             words_sent, settings_cnt, 4);
    $display("Checked %0d result words, %0d of them trigger firings; %0d mismatches.",
             sb.checked, sb.fires, sb.errors);
    if (sb.errors == 0) begin
      $display("averaged_threshold_trigger verification clean");
    end else begin
      $display("averaged_threshold_trigger verification failed");
    end
    $finish;
  end

endmodule
